[rtl/wildcard_ordered_match_table_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the ordered match table
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_ORDERED_MATCH_TABLE_ASSERT_SVH
`define WILDCARD_ORDERED_MATCH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define WOMT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WOMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WOMT_ASSERT(label, clk, rst_n, prop, msg)
`define WOMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/womt_pkg.sv]
// ---------------------------------------------------------------------------
// Ordered match table package
// Shared widths, operation codes and the item types.
// ---------------------------------------------------------------------------
package womt_pkg;
  localparam int DepthDef     = 16;
  localparam int UsageBitsDef = 16;
  localparam int MajW = 8;
  localparam int MinW = 10;
  localparam int HndW = 8;
  localparam int CntW = 5;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_FIND   = 3'd2,
    OP_INC    = 3'd3,
    OP_DEC    = 3'd4,
    OP_AVAIL  = 3'd5,
    OP_QUERY  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [MajW-1:0] major_code;
    logic [MinW-1:0] minor_code;
    logic [HndW-1:0] handler_in;
    logic            avail_in;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [HndW-1:0] handler_out;
    logic [MajW-1:0] matched_major;
    logic [MinW-1:0] matched_minor;
    logic            in_use;
    logic            available_out;
    logic [CntW-1:0] entry_count;
  } rsp_t;
endpackage

[rtl/womt_if.sv]
// ---------------------------------------------------------------------------
// Ordered match table channels
// Valid/ready channels for request and response items.
// ---------------------------------------------------------------------------
interface womt_req_if;
  import womt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface womt_rsp_if;
  import womt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/wildcard_ordered_match_table.sv]
// Throughput: one item at a time; the next is taken the cycle after the result leaves.
// The entry memory is read one slot at a time: address in SCAN, then compare in LOOK.
// Reset (rst_n, synchronous, active low) empties the table and the output stage;
//   the memory itself is not cleared, only slots below the entry count are read.
// ---------------------------------------------------------------------------
// Ordered match table top level
// Sequencer that scans, updates and compacts the entry memory.
// ---------------------------------------------------------------------------
module wildcard_ordered_match_table #(
  parameter int DEPTH      = womt_pkg::DepthDef,
  parameter int USAGE_BITS = womt_pkg::UsageBitsDef
) (
  input logic clk,
  input logic rst_n,
  womt_req_if.sink   in_ch,
  womt_rsp_if.source out_ch
);
  import womt_pkg::*;
  `include "wildcard_ordered_match_table_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int EW = MajW + MinW + HndW + USAGE_BITS + 1;
  localparam logic [USAGE_BITS-1:0] UsageMax = '1;

  typedef struct packed {
    logic [MajW-1:0]       mj;
    logic [MinW-1:0]       mn;
    logic [HndW-1:0]       hd;
    logic [USAGE_BITS-1:0] us;
    logic                  av;
  } ent_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LOOK, S_SHIFT, S_SHWR, S_DONE} st_t;

  st_t             st_r;
  req_t            req_r;
  logic [NW-1:0]   cnt_r;
  logic [NW-1:0]   idx_r;
  logic            hit_r;
  ent_t            hent_r;
  logic [AW-1:0]   hidx_r;
  logic            ovld_r;
  rsp_t            odat_r;
  logic            wb_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  ent_t            wdata, rd;
  logic [EW-1:0]   rraw;

  womt_mem #(.Depth(DEPTH), .Width(EW)) u_mem (
    .clk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rraw)
  );
  assign rd = ent_t'(rraw);

  logic wild, match;
  assign wild  = (req_r.major_code == '0) || (req_r.minor_code == '0);
  assign match = (req_r.op == OP_FIND && wild) ?
    ((req_r.major_code == '0 || req_r.major_code == rd.mj) &&
     (req_r.minor_code == '0 || req_r.minor_code == rd.mn) && rd.av) :
    (rd.mj == req_r.major_code && rd.mn == req_r.minor_code);

  logic erase_go;
  assign erase_go = (req_r.op == OP_ERASE) && hit_r && (hent_r.us == '0);

  assign in_ch.ready = (st_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = odat_r;

  always_comb begin
    raddr = idx_r[AW-1:0];
    if (st_r == S_IDLE) begin
      raddr = '0;
    end
    we    = wb_r;
    waddr = hidx_r;
    wdata = hent_r;
    if (st_r == S_SHWR) begin
      we    = 1'b1;
      waddr = AW'(idx_r - NW'(1));
      wdata = rd;
    end
  end

  ent_t newe;
  always_comb begin
    newe = hent_r;
    case (req_r.op)
      OP_INC:   if (hent_r.us != UsageMax) newe.us = hent_r.us + 1'b1;
      OP_DEC:   if (hent_r.us != '0) newe.us = hent_r.us - 1'b1;
      OP_AVAIL: newe.av = req_r.avail_in;
      default:  newe = hent_r;
    endcase
  end

  ent_t gone;
  always_comb begin
    gone    = hent_r;
    gone.us = '0;
    gone.av = 1'b0;
  end

  function automatic rsp_t mkrsp(input logic ok, input logic hit, input ent_t e,
                                 input req_t q, input logic [NW-1:0] c);
    rsp_t r;
    r.ok            = ok;
    r.handler_out   = (ok && hit) ? e.hd : '0;
    r.matched_major = (ok && hit) ? e.mj : q.major_code;
    r.matched_minor = (ok && hit) ? e.mn : q.minor_code;
    r.in_use        = hit && (e.us != '0);
    r.available_out = hit && e.av;
    r.entry_count   = CntW'(c);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
      idx_r  <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (ovld_r && out_ch.ready) begin
        ovld_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.data;
            idx_r <= '0;
            hit_r <= 1'b0;
            st_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r == cnt_r) begin
            st_r <= S_DONE;
          end else begin
            st_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (match) begin
            hit_r  <= 1'b1;
            hent_r <= rd;
            hidx_r <= idx_r[AW-1:0];
            st_r   <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_SCAN;
          end
        end
        S_SHIFT: begin
          if (idx_r == cnt_r) begin
            cnt_r  <= cnt_r - 1'b1;
            odat_r <= mkrsp(1'b1, 1'b1, gone, req_r, cnt_r - 1'b1);
            ovld_r <= 1'b1;
            st_r   <= S_IDLE;
          end else begin
            st_r <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx_r <= idx_r + 1'b1;
          st_r  <= S_SHIFT;
        end
        S_DONE: begin
          if (erase_go) begin
            idx_r <= NW'(hidx_r) + 1'b1;
            st_r  <= S_SHIFT;
          end else begin
            ovld_r <= 1'b1;
            st_r   <= S_IDLE;
          end
          case (req_r.op)
            OP_INSERT: begin
              if (!wild && !hit_r && cnt_r != NW'(DEPTH)) begin
                hent_r <= '{mj: req_r.major_code, mn: req_r.minor_code,
                            hd: req_r.handler_in, us: '0, av: 1'b1};
                hidx_r <= cnt_r[AW-1:0];
                cnt_r  <= cnt_r + 1'b1;
                odat_r <= mkrsp(1'b1, 1'b1,
                  '{mj: req_r.major_code, mn: req_r.minor_code,
                    hd: req_r.handler_in, us: '0, av: 1'b1}, req_r, cnt_r + 1'b1);
              end else begin
                odat_r <= mkrsp(1'b0, hit_r, hent_r, req_r, cnt_r);
              end
            end
            OP_ERASE: begin
              if (!erase_go) begin
                odat_r <= mkrsp(1'b0, hit_r, hent_r, req_r, cnt_r);
              end
            end
            OP_FIND:  odat_r <= mkrsp(hit_r && hent_r.av, hit_r, hent_r, req_r, cnt_r);
            OP_INC, OP_DEC, OP_AVAIL:
              odat_r <= mkrsp(hit_r, hit_r, newe, req_r, cnt_r);
            OP_QUERY: odat_r <= mkrsp(hit_r, hit_r, hent_r, req_r, cnt_r);
            default:  odat_r <= mkrsp(1'b0, hit_r, hent_r, req_r, cnt_r);
          endcase
          if (hit_r && (req_r.op == OP_INC || req_r.op == OP_DEC ||
                        req_r.op == OP_AVAIL)) begin
            hent_r <= newe;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // write back the modified or inserted entry in the cycle after DONE
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= 1'b0;
    end else begin
      wb_r <= (st_r == S_DONE) &&
              ((hit_r && (req_r.op == OP_INC || req_r.op == OP_DEC ||
                          req_r.op == OP_AVAIL)) ||
               (req_r.op == OP_INSERT && !wild && !hit_r && cnt_r != NW'(DEPTH)));
    end
  end

  `WOMT_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= NW'(DEPTH), "entry count above depth")
  `WOMT_ASSERT(a_ready_idle, clk, rst_n, !(in_ch.ready && st_r != S_IDLE),
    "ready outside idle")
  `WOMT_ASSERT_NEXT(a_one_item, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready,
    "second item accepted while busy")
  `WOMT_ASSERT(a_wb_shift, clk, rst_n, !(wb_r && st_r == S_SHWR), "write port conflict")
endmodule

[rtl/womt_mem.sv]
// ---------------------------------------------------------------------------
// Ordered match table entry store
// One write port, one registered read port; holds the packed entries.
// ---------------------------------------------------------------------------
module womt_mem #(
  parameter int Depth = 16,
  parameter int Width = 43
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// Ordered match table testbench
// Drives a table of directed operations, a fill to full and then random ones,
// predicts each response with a behavioural copy of the table and compares field by field.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import womt_pkg::*;

  localparam int Depth    = DepthDef;
  localparam int UsageMax = (1 << UsageBitsDef) - 1;
  localparam int NumRand  = 700;
  localparam int CycLimit = 400000;

  logic clk;
  logic rst_n;
  womt_req_if req_ch();
  womt_rsp_if rsp_ch();

  wildcard_ordered_match_table u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(rsp_ch.source)
  );

  typedef struct {
    op_t op;
    int  mj;
    int  mn;
    int  hnd;
    bit  av;
    bit  chk;
    bit  ok;
    int  cnt;
  } row_t;

  int   tbl_count;
  int   tbl_major[Depth];
  int   tbl_minor[Depth];
  int   tbl_handler[Depth];
  int   tbl_usage[Depth];
  bit   tbl_avail[Depth];
  rsp_t pending_rsp[$];
  int   errors;
  int   cycles = 0;
  bit   sink_idle_on;
  bit   src_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int find_key(int mj, int mn);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_major[i] == mj && tbl_minor[i] == mn) return i;
    return -1;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int mj, mn, idx, addr;
    bit ok, given;
    mj = int'(r.major_code);
    mn = int'(r.minor_code);
    idx = find_key(mj, mn);
    ok = 0;
    given = 0;
    addr = -1;
    o = '0;
    o.matched_major = r.major_code;
    o.matched_minor = r.minor_code;
    case (r.op)
      OP_INSERT: if (mj != 0 && mn != 0 && idx < 0 && tbl_count < Depth) begin
        tbl_major[tbl_count] = mj;
        tbl_minor[tbl_count] = mn;
        tbl_handler[tbl_count] = int'(r.handler_in);
        tbl_usage[tbl_count] = 0;
        tbl_avail[tbl_count] = 1;
        tbl_count++;
        ok = 1;
      end
      OP_ERASE: if (idx >= 0 && tbl_usage[idx] == 0) begin
        o.handler_out = HndW'(tbl_handler[idx]);
        for (int i = idx; i + 1 < tbl_count; i++) begin
          tbl_major[i] = tbl_major[i+1];
          tbl_minor[i] = tbl_minor[i+1];
          tbl_handler[i] = tbl_handler[i+1];
          tbl_usage[i] = tbl_usage[i+1];
          tbl_avail[i] = tbl_avail[i+1];
        end
        tbl_count--;
        ok = 1;
        given = 1;
      end
      OP_FIND: if (mj == 0 || mn == 0) begin
        given = 1;
        for (int i = 0; i < tbl_count; i++)
          if ((mj == 0 || mj == tbl_major[i]) && (mn == 0 || mn == tbl_minor[i]) &&
              tbl_avail[i]) begin
            addr = i;
            ok = 1;
            break;
          end
      end else if (idx >= 0 && tbl_avail[idx]) begin
        ok = 1;
      end
      OP_INC: if (idx >= 0) begin
        if (tbl_usage[idx] < UsageMax) tbl_usage[idx]++;
        ok = 1;
      end
      OP_DEC: if (idx >= 0) begin
        if (tbl_usage[idx] > 0) tbl_usage[idx]--;
        ok = 1;
      end
      OP_AVAIL: if (idx >= 0) begin
        tbl_avail[idx] = r.avail_in;
        ok = 1;
      end
      OP_QUERY: ok = idx >= 0;
      default: ;
    endcase
    if (!given) addr = find_key(mj, mn);
    if (ok && addr >= 0) begin
      o.handler_out = HndW'(tbl_handler[addr]);
      o.matched_major = MajW'(tbl_major[addr]);
      o.matched_minor = MinW'(tbl_minor[addr]);
    end else if (!ok) begin
      o.handler_out = '0;
    end
    o.ok = ok;
    o.in_use = addr >= 0 && tbl_usage[addr] != 0;
    o.available_out = addr >= 0 && tbl_avail[addr];
    o.entry_count = CntW'(tbl_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // sink side
  always @(posedge clk) begin
    rsp_t g, w;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      g = rsp_ch.data;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        w = pending_rsp.pop_front();
        if (g.ok !== w.ok) report_mismatch("ok", int'(g.ok), int'(w.ok));
        if (g.handler_out !== w.handler_out)
          report_mismatch("handler_out", int'(g.handler_out), int'(w.handler_out));
        if (g.matched_major !== w.matched_major)
          report_mismatch("matched_major", int'(g.matched_major), int'(w.matched_major));
        if (g.matched_minor !== w.matched_minor)
          report_mismatch("matched_minor", int'(g.matched_minor), int'(w.matched_minor));
        if (g.in_use !== w.in_use)
          report_mismatch("in_use", int'(g.in_use), int'(w.in_use));
        if (g.available_out !== w.available_out)
          report_mismatch("available_out", int'(g.available_out), int'(w.available_out));
        if (g.entry_count !== w.entry_count)
          report_mismatch("entry_count", int'(g.entry_count), int'(w.entry_count));
      end
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(req_t r, bit chk, bit ok_w, int cnt_w);
    rsp_t w;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    w = table_apply(r);
    if (chk && (w.ok != ok_w || int'(w.entry_count) != cnt_w))
      report_mismatch("directed row", int'(w.ok), int'(ok_w));
    pending_rsp = {pending_rsp, w};
    @(negedge clk);
  endtask

  function automatic req_t rand_item();
    req_t r;
    int k;
    r.op = op_t'($urandom_range(0, 7));
    r.handler_in = HndW'($urandom);
    r.avail_in = 1'($urandom);
    k = $urandom_range(0, 9);
    if (k < 6 && tbl_count > 0) begin
      k = $urandom_range(0, tbl_count - 1);
      r.major_code = MajW'(tbl_major[k]);
      r.minor_code = MinW'(tbl_minor[k]);
    end else begin
      r.major_code = MajW'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 5));
      r.minor_code = MinW'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 5));
      if ($urandom_range(0, 4) == 0) begin
        r.major_code = MajW'($urandom);
        r.minor_code = MinW'($urandom);
      end
    end
    if (r.op == OP_INSERT && tbl_count > 12 && $urandom_range(0, 1) == 1) r.op = OP_ERASE;
    if (r.op == OP_INC && $urandom_range(0, 1) == 1) r.op = OP_DEC;
    return r;
  endfunction

  row_t rows[] = '{
    '{OP_QUERY, 1, 1, 0, 0, 1, 0, 0},
    '{OP_INSERT, 0, 5, 1, 0, 1, 0, 0},
    '{OP_INSERT, 5, 0, 1, 0, 1, 0, 0},
    '{OP_INSERT, 255, 1023, 255, 0, 1, 1, 1},
    '{OP_INSERT, 255, 1023, 7, 0, 1, 0, 1},
    '{OP_INSERT, 1, 1, 0, 0, 1, 1, 2},
    '{OP_INSERT, 1, 2, 170, 0, 1, 1, 3},
    '{OP_FIND, 0, 0, 0, 0, 0, 0, 0},
    '{OP_FIND, 1, 0, 0, 0, 0, 0, 0},
    '{OP_FIND, 0, 2, 0, 0, 0, 0, 0},
    '{OP_AVAIL, 255, 1023, 0, 0, 1, 1, 3},
    '{OP_FIND, 255, 1023, 0, 0, 1, 0, 3},
    '{OP_FIND, 0, 0, 0, 0, 0, 0, 0},
    '{OP_INC, 1, 1, 0, 0, 1, 1, 3},
    '{OP_ERASE, 1, 1, 0, 0, 1, 0, 3},
    '{OP_DEC, 1, 1, 0, 0, 1, 1, 3},
    '{OP_DEC, 1, 1, 0, 0, 1, 1, 3},
    '{OP_ERASE, 1, 1, 0, 0, 1, 1, 2},
    '{OP_INC, 9, 9, 0, 0, 1, 0, 2},
    '{OP_QUERY, 1, 2, 0, 0, 0, 0, 0},
    '{OP_NONE, 1, 2, 0, 1, 1, 0, 2},
    '{OP_AVAIL, 255, 1023, 0, 1, 1, 1, 2},
    '{OP_FIND, 0, 1023, 0, 0, 0, 0, 0}
  };

  initial begin
    req_t r;
    errors = 0;
    src_idle_on = 0;
    sink_idle_on = 0;
    tbl_count = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) begin
      r.op = rows[i].op;
      r.major_code = MajW'(rows[i].mj);
      r.minor_code = MinW'(rows[i].mn);
      r.handler_in = HndW'(rows[i].hnd);
      r.avail_in = rows[i].av;
      send_item(r, rows[i].chk, rows[i].ok, rows[i].cnt);
    end
    // fill the table to full
    for (int i = 0; i < Depth + 1; i++) begin
      r = '0;
      r.op = OP_INSERT;
      r.major_code = 8'd200;
      r.minor_code = MinW'(512 + i);
      r.handler_in = HndW'(i);
      send_item(r, 0, 0, 0);
    end
    src_idle_on = 1;
    sink_idle_on = 1;
    for (int n = 0; n < NumRand; n++) begin
      if (n == NumRand / 2) begin
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
      end
      if (n == NumRand - 100) begin
        src_idle_on = 0;
        sink_idle_on = 0;
      end
      send_item(rand_item(), 0, 0, 0);
    end
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4 * Depth + 20) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/womt_pkg.sv
rtl/womt_if.sv
rtl/womt_mem.sv
rtl/wildcard_ordered_match_table.sv
test/tb_top.sv
